// ===== hw/rtl/smdr_pkg.sv =====
// shared types and constants for the scaled multiply-divide block
// no dependencies

package smdr_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned ProdW = 2 * DataW;
    localparam int unsigned MagW  = ProdW - 1;
    localparam int unsigned NCells = MagW;

    typedef enum logic [1:0] {
        ModeTrunc = 2'd0,
        ModeFloor = 2'd1,
        ModeCeil  = 2'd2,
        ModeSpare = 2'd3
    } smdr_mode_t;

    typedef struct packed {
        logic             valid;
        smdr_mode_t       mode;
        logic             qneg;
        logic             pneg;
        logic             dz;
        logic [DataW-1:0] dmag;
        logic [DataW-1:0] rem;
        logic [MagW-1:0]  num;
    } smdr_cell_t;

    typedef struct packed {
        logic signed [DataW-1:0] quotient;
        logic                    overflow;
        logic                    divide_by_zero;
    } smdr_res_t;

endpackage

// ===== hw/rtl/smdr_ifs.sv =====
// handshake channels for operand words and result words
// depends on nothing

interface smdr_op_if;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] z_value;

    modport source (output valid, action, x_value, y_value, z_value, input ready);
    modport sink (input valid, action, x_value, y_value, z_value, output ready);
endinterface

interface smdr_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] quotient;
    logic               overflow;
    logic               divide_by_zero;

    modport source (output valid, quotient, overflow, divide_by_zero, input ready);
    modport sink (input valid, quotient, overflow, divide_by_zero, output ready);
endinterface

// ===== hw/rtl/smdr_mul.sv =====
// front end: signed product, then magnitudes and signs for the divider chain
// depends on smdr_pkg

module smdr_mul (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid,
    input  logic [1:0]            action,
    input  logic signed [31:0]    x_value,
    input  logic signed [31:0]    y_value,
    input  logic signed [31:0]    z_value,
    output smdr_pkg::smdr_cell_t  dout
);
    import smdr_pkg::*;

    logic                    v1_reg;
    smdr_mode_t              mode1_reg;
    logic signed [ProdW-1:0] prod_reg;
    logic                    zneg_reg;
    logic                    dz_reg;
    logic [DataW-1:0]        zmag_reg;

    logic signed [ProdW-1:0] prod_next;
    logic [DataW-1:0]        zmag_next;
    logic [ProdW-1:0]        pabs;
    logic                    v2_reg;
    smdr_cell_t              cell_reg;
    smdr_cell_t              cell_next;

    always_comb
    begin
        prod_next = x_value * y_value;
        zmag_next = z_value[DataW-1] ? DataW'(-z_value) : DataW'(z_value);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode1_reg <= smdr_mode_t'(action);
            prod_reg  <= prod_next;
            zneg_reg  <= z_value[DataW-1];
            dz_reg    <= (z_value == '0);
            zmag_reg  <= zmag_next;
            cell_reg  <= cell_next;
        end
    end

    always_comb
    begin
        pabs            = prod_reg[ProdW-1] ? ProdW'(-prod_reg) : ProdW'(prod_reg);
        cell_next       = '0;
        cell_next.mode  = mode1_reg;
        cell_next.pneg  = prod_reg[ProdW-1];
        cell_next.qneg  = prod_reg[ProdW-1] ^ zneg_reg;
        cell_next.dz    = dz_reg;
        cell_next.dmag  = zmag_reg;
        cell_next.rem   = '0;
        cell_next.num   = pabs[MagW-1:0];
    end

    always_comb
    begin
        dout       = cell_reg;
        dout.valid = v2_reg;
    end

endmodule

// ===== hw/rtl/smdr_cell.sv =====
// one restoring division step: shifts in one dividend bit, yields one quotient bit
// depends on smdr_pkg

module smdr_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  smdr_pkg::smdr_cell_t din,
    output smdr_pkg::smdr_cell_t dout
);
    import smdr_pkg::*;

    logic             valid_reg;
    smdr_cell_t       data_reg;
    smdr_cell_t       data_next;
    logic [DataW:0]   trial;
    logic [DataW+1:0] diff;

    always_comb
    begin
        trial     = {din.rem, din.num[MagW-1]};
        diff      = {1'b0, trial} - {2'b00, din.dmag};
        data_next = din;
        if (!diff[DataW+1])
        begin
            data_next.rem = diff[DataW-1:0];
            data_next.num = {din.num[MagW-2:0], 1'b1};
        end
        else
        begin
            data_next.rem = trial[DataW-1:0];
            data_next.num = {din.num[MagW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    always_comb
    begin
        dout       = data_reg;
        dout.valid = valid_reg;
    end

endmodule

// ===== hw/rtl/smdr_fix.sv =====
// back end: applies sign and rounding, flags overflow and zero divisor
// depends on smdr_pkg

module smdr_fix (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  smdr_pkg::smdr_cell_t din,
    output logic                 valid,
    output smdr_pkg::smdr_res_t  res
);
    import smdr_pkg::*;

    logic              valid_reg;
    smdr_res_t         res_reg;
    smdr_res_t         res_next;
    logic [ProdW-1:0]  base;
    logic signed [2:0] addend;
    logic [ProdW-1:0]  qsum;
    logic              inexact;

    always_comb
    begin
        inexact = (din.rem != '0);
        base    = din.qneg ? ~{1'b0, din.num} : {1'b0, din.num};
        addend  = din.qneg ? 3'sd1 : 3'sd0;
        case (din.mode)
            ModeFloor:
                if (inexact && din.pneg)
                    addend = addend - 3'sd1;
            ModeCeil:
                if (inexact && !din.pneg)
                    addend = addend + 3'sd1;
            default:
                addend = addend;
        endcase
        qsum = base + ProdW'(signed'(addend));

        res_next = '0;
        if (din.dz)
            res_next.divide_by_zero = 1'b1;
        else
        begin
            res_next.quotient = qsum[DataW-1:0];
            res_next.overflow = !((qsum[ProdW-1:DataW-1] == '0)
                                || (qsum[ProdW-1:DataW-1] == '1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign valid = valid_reg;
    assign res   = res_reg;

endmodule

// ===== hw/rtl/scaled_muldiv_rounding.sv =====
// top level of the scaled multiply-divide block with selectable rounding
// depends on smdr_pkg, smdr_ifs, smdr_mul, smdr_cell, smdr_fix
//
// operands: valid/ready channel carrying action, x_value, y_value, z_value
// result: valid/ready channel carrying quotient, overflow, divide_by_zero
// a word is taken when valid and ready are both high at a rising edge
// computes x*y/z on the exact 64-bit product, truncated, then floor or ceiling
// correction by the sign of the remainder; low 32 bits plus overflow flag
// an accepted word passes the product, cell, fix and result registers in turn
// throughput: one word per cycle unless stalled, set by the 63-cell division chain where
// each cell resolves one quotient bit and passes its word on every cycle that en is high
// the result register is backed by a one-word skid buffer; the pipeline
// and operands.ready stall only once the skid buffer holds a word
// reset clears all valid bits; no words are held after reset

module scaled_muldiv_rounding (
    input  logic       clk,
    input  logic       rst_n,
    smdr_op_if.sink    operands,
    smdr_res_if.source result
);
    import smdr_pkg::*;

    logic       en;
    smdr_cell_t chain [NCells+1];
    logic       fix_valid;
    smdr_res_t  fix_res;

    logic      out_valid_reg;
    logic      out_valid_next;
    smdr_res_t out_data_reg;
    smdr_res_t out_data_next;
    logic      skid_full_reg;
    logic      skid_full_next;
    smdr_res_t skid_data_reg;
    smdr_res_t skid_data_next;
    logic      out_take;

    assign en             = !skid_full_reg;
    assign operands.ready = !skid_full_reg;

    smdr_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid   (operands.valid),
        .action  (operands.action),
        .x_value (operands.x_value),
        .y_value (operands.y_value),
        .z_value (operands.z_value),
        .dout    (chain[0])
    );

    for (genvar i = 0; i < NCells; i++)
    begin : g_cell
        smdr_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    smdr_fix u_fix (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (chain[NCells]),
        .valid (fix_valid),
        .res   (fix_res)
    );

    always_comb
    begin
        out_take       = out_valid_reg && result.ready;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        skid_full_next = skid_full_reg;
        skid_data_next = skid_data_reg;
        if (skid_full_reg)
        begin
            if (out_take)
            begin
                out_data_next  = skid_data_reg;
                skid_full_next = 1'b0;
            end
        end
        else if (fix_valid)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = fix_res;
            end
            else
            begin
                skid_full_next = 1'b1;
                skid_data_next = fix_res;
            end
        end
        else if (out_take)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.quotient       = out_data_reg.quotient;
    assign result.overflow       = out_data_reg.overflow;
    assign result.divide_by_zero = out_data_reg.divide_by_zero;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid word held without a result word in front");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(out_valid_reg && !result.ready))
        else $error("skid buffer filled without a stalled result");

    a_dz_result: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.divide_by_zero |-> result.quotient == '0 && !result.overflow)
        else $error("zero divisor result carries a nonzero quotient or overflow");

endmodule

// ===== bench/tb_scaled_muldiv_rounding.sv =====
// self-checking bench for scaled_muldiv_rounding: directed corner words, then random words
// with bursty operand traffic and a stalling result side; depends on smdr_pkg, smdr_ifs and rtl
`timescale 1ns / 1ps

module tb_scaled_muldiv_rounding;
    import smdr_pkg::*;

    localparam int unsigned RandomWords = 750;
    localparam int unsigned DrainCycles = 80;
    localparam int unsigned CycleLimit  = 400000;
    localparam longint      QMax        = 64'sd2147483647;
    localparam longint      QMin        = -QMax - 1;

    typedef struct {
        smdr_mode_t         mode;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } op_word_t;

    logic clk = 1'b0;
    logic rst_n;

    smdr_op_if  op_ch ();
    smdr_res_if res_ch ();

    scaled_muldiv_rounding uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (op_ch),
        .result   (res_ch)
    );

    op_word_t  operand_backlog[$];
    smdr_res_t quotient_expected[$];
    op_word_t  next_word;

    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned stall_style;
    int unsigned style_timer;
    int unsigned cycles;
    int unsigned failures;
    int unsigned results_checked;
    int unsigned overflow_seen;
    int unsigned zero_div_seen;
    int unsigned mode_count[4];

    always #5 clk = ~clk;

    function automatic smdr_res_t predict_quotient(op_word_t w);
        longint    prod;
        longint    q;
        longint    r;
        smdr_res_t res;
        res = '0;
        if (w.z == 0)
        begin
            res.divide_by_zero = 1'b1;
            return res;
        end
        prod = longint'(w.x) * longint'(w.y);
        q = prod / longint'(w.z);
        r = prod % longint'(w.z);
        // correction follows remainder sign, not true floor/ceiling for negative divisors
        case (w.mode)
            ModeFloor: if (r < 0) q = q - 1;
            ModeCeil:  if (r > 0) q = q + 1;
            default:   ;
        endcase
        res.quotient = q[31:0];
        res.overflow = (q < QMin) || (q > QMax);
        return res;
    endfunction

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(9))
            0:       return 32'sd0;
            1:       return 32'sd1;
            2:       return -32'sd1;
            3:       return 32'sd2;
            4:       return -32'sd2;
            5:       return 32'sh7fffffff;
            6:       return 32'sh80000000;
            7:       return 32'sh7ffffffe;
            8:       return 32'sh80000001;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_word(smdr_mode_t m, logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
        op_word_t w;
        w.mode = m;
        w.x = x;
        w.y = y;
        w.z = z;
        operand_backlog.push_back(w);
    endtask

    // operand driver: bursts of words separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_ch.valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!op_ch.valid || op_ch.ready)
        begin
            if (gap_left > 0)
            begin
                op_ch.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (operand_backlog.size() > 0)
            begin
                next_word = operand_backlog.pop_front();
                op_ch.action <= next_word.mode;
                op_ch.x_value <= next_word.x;
                op_ch.y_value <= next_word.y;
                op_ch.z_value <= next_word.z;
                op_ch.valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(40, 1);
                    gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                op_ch.valid <= 1'b0;
            end
        end
    end

    // result ready: style picked anew each time style_timer wraps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_style <= 0;
            style_timer <= 0;
        end
        else
        begin
            if (style_timer == 49)
            begin
                style_timer <= 0;
                stall_style <= $urandom_range(3);
            end
            else
            begin
                style_timer <= style_timer + 1;
            end
            case (stall_style)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= $urandom_range(1);
                2:       res_ch.ready <= ($urandom_range(3) == 0);
                default: res_ch.ready <= (style_timer % 7) < 4;
            endcase
        end
    end

    // monitor: predict on operand acceptance, check on result acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (op_ch.valid && op_ch.ready)
            begin
                op_word_t w;
                w.mode = smdr_mode_t'(op_ch.action);
                w.x = op_ch.x_value;
                w.y = op_ch.y_value;
                w.z = op_ch.z_value;
                quotient_expected.push_back(predict_quotient(w));
                mode_count[op_ch.action] <= mode_count[op_ch.action] + 1;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                smdr_res_t exp_res;
                if (quotient_expected.size() == 0)
                begin
                    $error("result word with nothing expected: quotient %0d", res_ch.quotient);
                    failures++;
                end
                else
                begin
                    exp_res = quotient_expected.pop_front();
                    results_checked++;
                    if (exp_res.overflow) overflow_seen++;
                    if (exp_res.divide_by_zero) zero_div_seen++;
                    if (res_ch.quotient !== exp_res.quotient)
                    begin
                        $error("quotient: expected %0d, got %0d",
                               exp_res.quotient, res_ch.quotient);
                        failures++;
                    end
                    if (res_ch.overflow !== exp_res.overflow)
                    begin
                        $error("overflow: expected %0b, got %0b",
                               exp_res.overflow, res_ch.overflow);
                        failures++;
                    end
                    if (res_ch.divide_by_zero !== exp_res.divide_by_zero)
                    begin
                        $error("divide_by_zero: expected %0b, got %0b",
                               exp_res.divide_by_zero, res_ch.divide_by_zero);
                        failures++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycles, quotient_expected.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int unsigned        kind;
        smdr_mode_t         m;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;

        rst_n = 1'b0;
        cycles = 0;
        failures = 0;
        results_checked = 0;
        overflow_seen = 0;
        zero_div_seen = 0;
        mode_count = '{default: 0};
        op_ch.valid = 1'b0;
        op_ch.action = ModeTrunc;
        op_ch.x_value = '0;
        op_ch.y_value = '0;
        op_ch.z_value = '0;
        res_ch.ready = 1'b0;

        // basic rounding in every mode
        add_word(ModeTrunc, 7, 3, 2);
        add_word(ModeFloor, 7, 3, 2);
        add_word(ModeCeil, 7, 3, 2);
        add_word(ModeSpare, 7, 3, 2);
        add_word(ModeFloor, -7, 3, 2);
        add_word(ModeCeil, -7, 3, 2);
        // negative divisor: correction by remainder sign
        add_word(ModeFloor, 5, 1, -2);
        add_word(ModeCeil, 5, 1, -2);
        // zero divisor
        add_word(ModeFloor, 32'sh7fffffff, 32'sh80000000, 0);
        add_word(ModeSpare, -1, -1, 0);
        // wide quotients
        add_word(ModeTrunc, 32'sh80000000, 32'sh80000000, 1);
        add_word(ModeCeil, 32'sh80000000, 32'sh80000000, -1);
        add_word(ModeTrunc, 32'sh80000000, 1, -1);
        add_word(ModeFloor, 32'sh80000000, -1, 1);
        add_word(ModeTrunc, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        add_word(ModeCeil, 32'sh7fffffff, 1, 1);
        add_word(ModeFloor, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        add_word(ModeFloor, 0, 32'sh7fffffff, 3);
        // rounding pushes to or just past the range limits
        add_word(ModeCeil, 65535, 65537, 2);
        add_word(ModeFloor, -641, 6700417, 2);
        add_word(ModeFloor, -65535, 65537, 2);

        for (int unsigned i = 0; i < RandomWords; i++)
        begin
            kind = $urandom_range(99);
            m = smdr_mode_t'($urandom_range(3));
            if (kind < 40)
            begin
                x = int'($urandom_range(2000)) - 1000;
                y = int'($urandom_range(2000)) - 1000;
                z = int'($urandom_range(100)) - 50;
            end
            else if (kind < 52)
            begin
                // plain division with y = 1, in a random mode
                x = $urandom;
                y = 1;
                z = ($urandom_range(1) == 0) ? int'($urandom_range(200)) - 100 : $urandom;
            end
            else if (kind < 67)
            begin
                x = $urandom;
                y = $urandom;
                z = $urandom;
            end
            else if (kind < 80)
            begin
                x = pick_extreme();
                y = pick_extreme();
                z = pick_extreme();
            end
            else if (kind < 95)
            begin
                // quotient near x, where x is often an extreme value
                x = ($urandom_range(1) == 0) ? pick_extreme() : $urandom;
                y = int'($urandom_range(131072)) - 65536;
                z = y + int'($urandom_range(4)) - 2;
            end
            else
            begin
                x = $urandom;
                y = $urandom;
                z = 0;
            end
            add_word(m, x, y, z);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (operand_backlog.size() != 0 || op_ch.valid)
            @(posedge clk);
        while (quotient_expected.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("%0d results checked: %0d trunc, %0d floor, %0d ceil, %0d spare mode words",
                 results_checked, mode_count[ModeTrunc], mode_count[ModeFloor],
                 mode_count[ModeCeil], mode_count[ModeSpare]);
        $display("%0d overflowed, %0d divided by zero, %0d mismatches",
                 overflow_seen, zero_div_seen, failures);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
